>>> src/vcfs_pkg.sv
`timescale 1ns / 1ps

package vcfs_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int PERIOD_W = 16;
  localparam int NPER_W = 8;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hf424;
  localparam logic [NPER_W-1:0] CHARGE_RESET = 8'd4;
  localparam logic [NPER_W-1:0] FIRE_RESET = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DISARMED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNCHARGED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHARGING = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHARGED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIRE_REQ = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIRE_WAIT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FIRING = 3'd6;

  localparam logic [2:0] CMD_FIRE_START = 3'd1;
  localparam logic [2:0] CMD_FIRE_ABORT = 3'd2;
  localparam logic [2:0] CMD_ARM = 3'd3;
  localparam logic [2:0] CMD_DISARM = 3'd4;

  localparam logic REQ_TICK = 1'b0;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ticks;
    logic [NPER_W-1:0] charge_periods;
    logic [NPER_W-1:0] fire_periods;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic feed_valve;
    logic release_valve;
    logic armed_lamp;
    logic feed_lamp;
    logic release_lamp;
  } result_t;

endpackage

>>> src/vcfs_cfg.sv
`timescale 1ns / 1ps

module vcfs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [vcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output vcfs_pkg::cfg_t                      cfg
);
  import vcfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= PERIOD_RESET;
      cfg.charge_periods <= CHARGE_RESET;
      cfg.fire_periods <= FIRE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD: cfg.period_ticks <= cfg_data[PERIOD_W-1:0];
        REG_CHARGE: cfg.charge_periods <= cfg_data[NPER_W-1:0];
        REG_FIRE: cfg.fire_periods <= cfg_data[NPER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/vcfs_seq.sv
`timescale 1ns / 1ps

module vcfs_seq #(
  parameter int COUNT_WIDTH = vcfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              req_type,
  input  logic [2:0]        command,
  input  vcfs_pkg::cfg_t    cfg,
  output vcfs_pkg::result_t result_next
);
  import vcfs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [MODE_W-1:0] mode_reg, mode_reg_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [NPER_W-1:0] periods_left, periods_left_next;
  logic timer_on, timer_on_next;
  logic [1:0] valve_bits, valve_bits_next;
  logic [2:0] lamp_bits, lamp_bits_next;

  always_comb begin
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [31:0] period;
    logic [MODE_W-1:0] m;
    logic [COUNT_WIDTH-1:0] tc;
    logic [NPER_W-1:0] pl;
    logic on;
    logic [1:0] vb;
    logic [2:0] lb;

    m = mode_reg;
    tc = tick_count;
    pl = periods_left;
    on = timer_on;
    vb = valve_bits;
    lb = lamp_bits;
    cnt_inc = tick_count + 1'b1;
    period = (cfg.period_ticks == '0) ? 32'd1 : 32'(cfg.period_ticks);

    if (req_type == REQ_TICK) begin
      if (on) begin
        if ((32'(cnt_inc) < period) && (cnt_inc != COUNT_MAX)) begin
          tc = cnt_inc;
        end else begin
          tc = '0;
          if (pl > 8'd1) begin
            pl = pl - 1'b1;
          end else begin
            pl = '0;
            on = 1'b0;
            vb = 2'b00;
            if (m == MODE_CHARGING) begin
              m = MODE_CHARGED;
            end else if (m == MODE_FIRE_WAIT) begin
              m = MODE_FIRE_REQ;
            end else if (m == MODE_FIRING) begin
              m = MODE_UNCHARGED;
            end
          end
        end
      end
    end else begin
      case (command)
        CMD_FIRE_START: begin
          if (m == MODE_CHARGED) begin
            m = MODE_FIRE_REQ;
          end else begin
            if (m != MODE_CHARGING && m != MODE_DISARMED) begin
              vb = 2'b01;
              tc = '0;
              pl = cfg.charge_periods;
              on = 1'b1;
            end
            m = MODE_FIRE_WAIT;
          end
        end
        CMD_FIRE_ABORT: begin
          vb = 2'b00;
          if (m != MODE_CHARGED) begin
            m = MODE_UNCHARGED;
          end
        end
        CMD_ARM: begin
          m = MODE_UNCHARGED;
          lb[0] = 1'b1;
        end
        CMD_DISARM: begin
          vb = 2'b00;
          m = MODE_DISARMED;
          lb[0] = 1'b0;
        end
        default: ;
      endcase
    end

    if (m == MODE_UNCHARGED) begin
      m = MODE_CHARGING;
      vb = 2'b01;
      tc = '0;
      pl = cfg.charge_periods;
      on = 1'b1;
    end else if (m == MODE_FIRE_REQ) begin
      m = MODE_FIRING;
      vb = 2'b10;
      tc = '0;
      pl = cfg.fire_periods;
      on = 1'b1;
    end

    case (m)
      MODE_DISARMED: lb = 3'b000;
      MODE_UNCHARGED, MODE_CHARGED, MODE_FIRE_REQ: lb = 3'b001;
      MODE_CHARGING: lb = 3'b011;
      MODE_FIRING: lb = 3'b101;
      default: ;
    endcase

    mode_reg_next = m;
    tick_count_next = tc;
    periods_left_next = pl;
    timer_on_next = on;
    valve_bits_next = vb;
    lamp_bits_next = lb;

    result_next.mode = m;
    result_next.feed_valve = vb[0];
    result_next.release_valve = vb[1];
    result_next.armed_lamp = lb[0];
    result_next.feed_lamp = lb[1];
    result_next.release_lamp = lb[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_DISARMED;
      tick_count <= '0;
      periods_left <= '0;
      timer_on <= 1'b0;
      valve_bits <= 2'b00;
      lamp_bits <= 3'b110;
    end else if (take) begin
      mode_reg <= mode_reg_next;
      tick_count <= tick_count_next;
      periods_left <= periods_left_next;
      timer_on <= timer_on_next;
      valve_bits <= valve_bits_next;
      lamp_bits <= lamp_bits_next;
    end
  end

endmodule

>>> src/vcfs_out.sv
`timescale 1ns / 1ps

module vcfs_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  vcfs_pkg::result_t result_next,
  input  logic              out_stall,
  output logic              out_valid,
  output vcfs_pkg::result_t result
);
  import vcfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

>>> src/valve_charge_fire_sequencer_unit.sv
`timescale 1ns / 1ps
// Arm, charge and fire sequencer for a feed valve and a release valve.
// Input channel (in_valid, in_stall): each transfer is one timer tick
// (req_type 0) or one radio command (req_type 1, command field).
// Output channel (out_valid, out_stall): exactly one result per input
// transfer, carrying the mode, both valve outputs and the three lamps.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data):
// index 0 period ticks, 1 charge periods, 2 fire periods; other indexes
// are ignored. cfg_ready is always high. Write only while the block is idle.
// The result is registered: the result of an item accepted at one edge is
// valid after that edge. The sequencer state update is short combinational
// logic between the state registers, so one item is taken every cycle
// while in_stall is low. When the receiver stalls, the result is held in
// the output register and in_stall rises until that result is transferred.
// Reset is synchronous: the sequencer comes up disarmed with the timer
// stopped, both valves closed, and configuration at its defaults.
module valve_charge_fire_sequencer_unit #(
  parameter int COUNT_WIDTH = vcfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [2:0]                          command,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vcfs_pkg::MODE_W-1:0]         mode,
  output logic                                feed_valve,
  output logic                                release_valve,
  output logic                                armed_lamp,
  output logic                                feed_lamp,
  output logic                                release_lamp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vcfs_pkg::*;

  cfg_t cfg;
  result_t result_next;
  result_t result;
  logic take;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid & out_stall;
  assign take = in_valid & ~in_stall;

  vcfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vcfs_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .req_type    (req_type),
    .command     (command),
    .cfg         (cfg),
    .result_next (result_next)
  );

  vcfs_out u_out (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .result_next (result_next),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .result      (result)
  );

  assign mode = result.mode;
  assign feed_valve = result.feed_valve;
  assign release_valve = result.release_valve;
  assign armed_lamp = result.armed_lamp;
  assign feed_lamp = result.feed_lamp;
  assign release_lamp = result.release_lamp;

endmodule
